/* sv/lbfgs_pkg.sv */
// ----------------------------------------------------------------------------
// lbfgs_pkg
// Shared codes, control bundles and the saturation helper of the L-BFGS
// direction engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lbfgs_pkg;

   localparam int DATA_W    = 32;
   localparam int STEP_IDX_W = 5;   // covers the largest history depth
   localparam int VAR_IDX_W  = 6;   // covers the largest vector length

   localparam logic [1:0] FUNC_LOAD_PAIR = 2'd0;
   localparam logic [1:0] FUNC_LOAD_GRAD = 2'd1;
   localparam logic [1:0] FUNC_START     = 2'd2;

   localparam logic CSR_VARS  = 1'b0;
   localparam logic CSR_STEPS = 1'b1;

   // pass kinds of the vector pipeline
   localparam logic [2:0] MODE_DOT_SY = 3'd0;
   localparam logic [2:0] MODE_DOT_SW = 3'd1;
   localparam logic [2:0] MODE_DOT_YW = 3'd2;
   localparam logic [2:0] MODE_UPD_Y  = 3'd3;
   localparam logic [2:0] MODE_SCALE  = 3'd4;
   localparam logic [2:0] MODE_UPD_S  = 3'd5;
   localparam logic [2:0] MODE_OUT    = 3'd6;

   typedef struct packed {
      logic                  valid;
      logic                  first;
      logic                  last;
      logic [2:0]            mode;
      logic [STEP_IDX_W-1:0] step;
      logic [VAR_IDX_W-1:0]  var_idx;
   } pass_ctl_type;

   typedef struct packed {
      logic                     pair_we;
      logic                     grad_we;
      logic [STEP_IDX_W-1:0]    step;
      logic [VAR_IDX_W-1:0]     var_idx;
      logic signed [DATA_W-1:0] s_value;
      logic signed [DATA_W-1:0] y_value;
      logic signed [DATA_W-1:0] grad_value;
   } load_type;

   typedef struct packed {
      logic                     valid;
      logic                     last;
      logic [VAR_IDX_W-1:0]     index;
      logic signed [DATA_W-1:0] value;
   } emit_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sh0000_0000_7FFF_FFFF;
      lo = -64'sh0000_0000_8000_0000;
      if (v > hi) begin
         sat32 = 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         sat32 = 32'sh8000_0000;
      end else begin
         sat32 = v[DATA_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

/* sv/lbfgs_divider.sv */
// ----------------------------------------------------------------------------
// lbfgs_divider
// Restoring divider forming the saturated quotient 2^32 / d, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lbfgs_divider (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                go,
   input  wire logic signed [lbfgs_pkg::DATA_W-1:0] divisor,
   output logic                                     done,
   output logic signed [lbfgs_pkg::DATA_W-1:0]      quotient
);

   logic        run_ff;
   logic        done_ff;
   logic [5:0]  cnt_ff;
   logic [32:0] rem_ff;
   logic [32:0] quo_ff;
   logic [32:0] mag_ff;
   logic        neg_ff;
   logic [33:0] trial;
   logic        qbit;

   // dividend is a single one at bit 32
   assign trial = {rem_ff, (cnt_ff == 6'd32)};
   assign qbit  = (trial >= {1'b0, mag_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            run_ff <= 1'b1;
            cnt_ff <= 6'd32;
            rem_ff <= '0;
            quo_ff <= '0;
            neg_ff <= divisor[31];
            mag_ff <= divisor[31] ? (33'd0 - {divisor[31], divisor})
                                  : {1'b0, divisor};
         end else if (run_ff) begin
            rem_ff <= qbit ? 33'(trial - {1'b0, mag_ff}) : trial[32:0];
            quo_ff <= {quo_ff[31:0], qbit};
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   logic [32:0] neg_quo;
   assign neg_quo = 33'd0 - quo_ff;

   always_comb begin
      if (neg_ff) begin
         quotient = (quo_ff > 33'h0_8000_0000) ? 32'sh8000_0000 : neg_quo[31:0];
      end else begin
         quotient = (quo_ff > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : quo_ff[31:0];
      end
   end

   assign done = done_ff;

endmodule

`default_nettype wire

/* sv/lbfgs_datapath.sv */
// ----------------------------------------------------------------------------
// lbfgs_datapath
// History and work vector memories with a three stage multiply pipeline:
// read, multiply, then accumulate or read-modify-write of the work vector.
// ----------------------------------------------------------------------------
`default_nettype none

module lbfgs_datapath #(
   parameter int MAX_VARS  = 64,
   parameter int MAX_STEPS = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire lbfgs_pkg::load_type                 load,
   input  wire lbfgs_pkg::pass_ctl_type             ctl,
   input  wire logic signed [lbfgs_pkg::DATA_W-1:0] coef,
   input  wire logic signed [lbfgs_pkg::DATA_W-1:0] h_scale,
   output logic signed [49+$clog2(MAX_VARS+1):0]    acc,
   output logic                                     pipe_busy,
   output lbfgs_pkg::emit_type                      emit
);

   localparam int DEPTH  = MAX_VARS * MAX_STEPS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int VAR_W  = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
   localparam int ACC_W  = 50 + $clog2(MAX_VARS+1);

   logic signed [31:0] s_mem [DEPTH];
   logic signed [31:0] y_mem [DEPTH];
   logic signed [31:0] w_mem [MAX_VARS];

   logic [ADDR_W-1:0] load_addr;
   logic [ADDR_W-1:0] rd_addr;
   assign load_addr = ADDR_W'(int'(load.step) * MAX_VARS + int'(load.var_idx));
   assign rd_addr   = ADDR_W'(int'(ctl.step) * MAX_VARS + int'(ctl.var_idx));

   logic signed [31:0] s_rd_ff, y_rd_ff, w_rd_ff;

   always_ff @(posedge clock) begin
      if (load.pair_we) begin
         s_mem[load_addr] <= load.s_value;
         y_mem[load_addr] <= load.y_value;
      end
      s_rd_ff <= s_mem[rd_addr];
      y_rd_ff <= y_mem[rd_addr];
   end

   // stage 1 and 2 tags
   logic               v1_ff, v2_ff;
   logic               last1_ff, last2_ff, first1_ff, first2_ff;
   logic [2:0]         mode1_ff, mode2_ff;
   logic [VAR_W-1:0]   j1_ff, j2_ff;
   logic signed [31:0] w2_ff;
   logic signed [63:0] prod_ff;
   logic signed [31:0] op_a, op_b;

   always_comb begin
      unique case (mode1_ff)
         lbfgs_pkg::MODE_DOT_SY: begin op_a = s_rd_ff; op_b = y_rd_ff; end
         lbfgs_pkg::MODE_DOT_SW: begin op_a = s_rd_ff; op_b = w_rd_ff; end
         lbfgs_pkg::MODE_DOT_YW: begin op_a = y_rd_ff; op_b = w_rd_ff; end
         lbfgs_pkg::MODE_UPD_Y:  begin op_a = coef;    op_b = y_rd_ff; end
         lbfgs_pkg::MODE_SCALE:  begin op_a = h_scale; op_b = w_rd_ff; end
         lbfgs_pkg::MODE_UPD_S:  begin op_a = s_rd_ff; op_b = coef;    end
         default:                begin op_a = '0;      op_b = '0;      end
      endcase
   end

   logic signed [47:0] sh;
   logic signed [31:0] w_new;
   logic               w_upd;
   logic signed [ACC_W-1:0] acc_ff;

   assign sh = prod_ff[63:16];   // floor toward minus infinity

   always_comb begin
      w_upd = v2_ff;
      unique case (mode2_ff)
         lbfgs_pkg::MODE_UPD_Y: w_new = lbfgs_pkg::sat32(64'(w2_ff) - 64'(sh));
         lbfgs_pkg::MODE_UPD_S: w_new = lbfgs_pkg::sat32(64'(w2_ff) + 64'(sh));
         lbfgs_pkg::MODE_SCALE: w_new = lbfgs_pkg::sat32(64'(sh));
         default: begin
            w_new = w2_ff;
            w_upd = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load.grad_we) begin
         w_mem[load.var_idx[VAR_W-1:0]] <= load.grad_value;
      end else if (w_upd) begin
         w_mem[j2_ff] <= w_new;
      end
      w_rd_ff <= w_mem[ctl.var_idx[VAR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= ctl.valid;
         v2_ff <= v1_ff;
      end
      mode1_ff  <= ctl.mode;
      last1_ff  <= ctl.last;
      first1_ff <= ctl.first;
      j1_ff     <= ctl.var_idx[VAR_W-1:0];
      mode2_ff  <= mode1_ff;
      last2_ff  <= last1_ff;
      first2_ff <= first1_ff;
      j2_ff     <= j1_ff;
      w2_ff     <= w_rd_ff;
      prod_ff   <= op_a * op_b;
   end

   logic dot2;
   assign dot2 = (mode2_ff == lbfgs_pkg::MODE_DOT_SY) ||
                 (mode2_ff == lbfgs_pkg::MODE_DOT_SW) ||
                 (mode2_ff == lbfgs_pkg::MODE_DOT_YW);

   always_ff @(posedge clock) begin
      if (v2_ff && dot2) begin
         acc_ff <= (first2_ff ? ACC_W'(0) : acc_ff) + ACC_W'(sh);
      end
   end

   assign acc       = acc_ff;
   assign pipe_busy = v1_ff | v2_ff;

   always_comb begin
      emit.valid = v2_ff && (mode2_ff == lbfgs_pkg::MODE_OUT);
      emit.last  = last2_ff;
      emit.index = lbfgs_pkg::VAR_IDX_W'(j2_ff);
      emit.value = w2_ff;
   end

endmodule

`default_nettype wire

/* sv/lbfgs_two_loop_direction_top.sv */
// ----------------------------------------------------------------------------
// lbfgs_two_loop_direction_top
// L-BFGS two-loop recursion engine in signed Q16.16, emitting H*g.
// ----------------------------------------------------------------------------
// Use: an item transfers at a clock edge with start high and busy low.
// Load items (pair element, gradient element) leave busy low, so they
// stream back to back. A start item raises busy for the whole recursion; the
// gradient must be reloaded before each start, as the run overwrites it.
// All work goes through one multiply pipeline on the s, y and work vector
// memories, one element a cycle; each pass drains before the next. The rho
// phase runs a bit-serial divide for each pair (a pair with zero s.y skips
// the divide and raises the curvature error).
// Results come out on rsp_valid one element a cycle, index 0 first, the
// final one marked by rsp_last; the receiver cannot stall and busy stays high
// until the last result has been shown. Write configuration only while idle;
// a run uses the counts latched at its start. Reset clears control and error
// state and sets the vector length to 64 and the pair count to 0; memory
// contents stay undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module lbfgs_two_loop_direction_top #(
   parameter int MAX_VARS  = 64,
   parameter int MAX_STEPS = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_func,
   input  wire logic [2:0]         req_step_index,
   input  wire logic [5:0]         req_var_index,
   input  wire logic signed [31:0] req_s_value,
   input  wire logic signed [31:0] req_y_value,
   input  wire logic signed [31:0] req_grad_value,
   input  wire logic signed [31:0] req_h_scale,
   output logic                    rsp_valid,
   output logic [5:0]              rsp_out_index,
   output logic signed [31:0]      rsp_direction_value,
   output logic                    rsp_last,
   output logic                    rsp_curvature_error,
   input  wire logic               csr_we,
   input  wire logic               csr_index,
   input  wire logic [6:0]         csr_wdata
);

   localparam int VAR_W  = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
   localparam int STEP_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
   localparam int NCNT_W = $clog2(MAX_VARS+1);
   localparam int MCNT_W = $clog2(MAX_STEPS+1);
   localparam int ACC_W  = 50 + $clog2(MAX_VARS+1);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_RHO_DOT = 4'd1;
   localparam logic [3:0] S_RHO_DIV = 4'd2;
   localparam logic [3:0] S_BK_DOT  = 4'd3;
   localparam logic [3:0] S_BK_MUL  = 4'd4;
   localparam logic [3:0] S_BK_SAT  = 4'd5;
   localparam logic [3:0] S_BK_UPD  = 4'd6;
   localparam logic [3:0] S_SCALE   = 4'd7;
   localparam logic [3:0] S_FW_DOT  = 4'd8;
   localparam logic [3:0] S_FW_MUL  = 4'd9;
   localparam logic [3:0] S_FW_SAT  = 4'd10;
   localparam logic [3:0] S_FW_UPD  = 4'd11;
   localparam logic [3:0] S_OUT     = 4'd12;
   localparam logic [3:0] S_DRAIN   = 4'd13;

   logic [3:0]          state_ff, state_in, after_ff;
   logic [STEP_W-1:0]   i_ff;
   logic [VAR_W-1:0]    j_ff;
   logic [NCNT_W-1:0]   n_ff;
   logic [MCNT_W-1:0]   m_ff;
   logic [6:0]          vars_ff;
   logic [3:0]          steps_ff;
   logic signed [31:0]  h_ff, coef_ff;
   logic signed [63:0]  cprod_ff;
   logic                err_ff, div_run_ff;
   logic signed [31:0]  rho_ff   [MAX_STEPS];
   logic signed [31:0]  alpha_ff [MAX_STEPS];
   logic                rsp_valid_ff, rsp_last_ff;
   logic [5:0]          rsp_index_ff;
   logic signed [31:0]  rsp_value_ff;

   lbfgs_pkg::load_type     load;
   lbfgs_pkg::pass_ctl_type ctl;
   lbfgs_pkg::emit_type     emit;
   logic signed [ACC_W-1:0] acc;
   logic                    pipe_busy;
   logic                    div_go, div_done;
   logic signed [31:0]      div_q, dot_sat, beta;
   logic                    accept, j_last, i_last, in_pass;
   logic [NCNT_W-1:0]       n_eff;
   logic [MCNT_W-1:0]       m_eff;

   assign accept  = start && (state_ff == S_IDLE);
   assign busy    = (state_ff != S_IDLE);
   assign dot_sat = lbfgs_pkg::sat32(64'(acc));
   assign j_last  = (NCNT_W'(j_ff) == n_ff - NCNT_W'(1));
   assign i_last  = (MCNT_W'(i_ff) == m_ff - MCNT_W'(1));
   assign beta    = lbfgs_pkg::sat32(64'($signed(cprod_ff[63:16])));

   assign n_eff = (vars_ff == 7'd0) ? NCNT_W'(1) :
                  (int'(vars_ff) > MAX_VARS) ? NCNT_W'(MAX_VARS) : NCNT_W'(vars_ff);
   assign m_eff = (int'(steps_ff) > MAX_STEPS) ? MCNT_W'(MAX_STEPS) : MCNT_W'(steps_ff);

   always_comb begin
      load.pair_we    = accept && (req_func == lbfgs_pkg::FUNC_LOAD_PAIR) &&
                        (int'(req_step_index) < MAX_STEPS) &&
                        (int'(req_var_index) < MAX_VARS);
      load.grad_we    = accept && (req_func == lbfgs_pkg::FUNC_LOAD_GRAD) &&
                        (int'(req_var_index) < MAX_VARS);
      load.step       = lbfgs_pkg::STEP_IDX_W'(req_step_index);
      load.var_idx    = req_var_index;
      load.s_value    = req_s_value;
      load.y_value    = req_y_value;
      load.grad_value = req_grad_value;
   end

   always_comb begin
      in_pass = 1'b1;
      ctl.mode = lbfgs_pkg::MODE_OUT;
      unique case (state_ff)
         S_RHO_DOT: ctl.mode = lbfgs_pkg::MODE_DOT_SY;
         S_BK_DOT:  ctl.mode = lbfgs_pkg::MODE_DOT_SW;
         S_BK_UPD:  ctl.mode = lbfgs_pkg::MODE_UPD_Y;
         S_SCALE:   ctl.mode = lbfgs_pkg::MODE_SCALE;
         S_FW_DOT:  ctl.mode = lbfgs_pkg::MODE_DOT_YW;
         S_FW_UPD:  ctl.mode = lbfgs_pkg::MODE_UPD_S;
         S_OUT:     ctl.mode = lbfgs_pkg::MODE_OUT;
         default:   in_pass = 1'b0;
      endcase
      ctl.valid   = in_pass;
      ctl.first   = (j_ff == '0);
      ctl.last    = j_last;
      ctl.step    = lbfgs_pkg::STEP_IDX_W'(i_ff);
      ctl.var_idx = lbfgs_pkg::VAR_IDX_W'(j_ff);
   end

   assign div_go = (state_ff == S_RHO_DIV) && !div_run_ff && (dot_sat != 32'sd0);

   lbfgs_datapath #(.MAX_VARS(MAX_VARS), .MAX_STEPS(MAX_STEPS)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .ctl       (ctl),
      .coef      (coef_ff),
      .h_scale   (h_ff),
      .acc       (acc),
      .pipe_busy (pipe_busy),
      .emit      (emit)
   );

   lbfgs_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .divisor  (dot_sat),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_func == lbfgs_pkg::FUNC_START)) begin
               state_in = (m_eff == '0) ? S_SCALE : S_RHO_DOT;
            end
         end
         S_RHO_DOT, S_BK_DOT, S_BK_UPD, S_SCALE, S_FW_DOT, S_FW_UPD, S_OUT: begin
            if (j_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (!pipe_busy) state_in = after_ff;
         end
         S_RHO_DIV: begin
            if ((!div_run_ff && dot_sat == 32'sd0) || (div_run_ff && div_done)) begin
               state_in = i_last ? S_BK_DOT : S_RHO_DOT;
            end
         end
         S_BK_MUL: state_in = S_BK_SAT;
         S_BK_SAT: state_in = S_BK_UPD;
         S_FW_MUL: state_in = S_FW_SAT;
         S_FW_SAT: state_in = S_FW_UPD;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         err_ff       <= 1'b0;
         div_run_ff   <= 1'b0;
         vars_ff      <= 7'd64;
         steps_ff     <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= emit.valid;
         if (csr_we) begin
            unique case (csr_index)
               lbfgs_pkg::CSR_VARS:  vars_ff  <= csr_wdata;
               lbfgs_pkg::CSR_STEPS: steps_ff <= csr_wdata[3:0];
               default: ;
            endcase
         end
         if (accept && (req_func == lbfgs_pkg::FUNC_START)) begin
            err_ff <= 1'b0;
         end
         if (state_ff == S_RHO_DIV && !div_run_ff && dot_sat == 32'sd0) begin
            err_ff <= 1'b1;
         end
         if (div_go) begin
            div_run_ff <= 1'b1;
         end else if (div_done) begin
            div_run_ff <= 1'b0;
         end
      end
   end

   // sequencing payload: result registers, counters, scalars and per-pair coefficients
   always_ff @(posedge clock) begin
      if (emit.valid) begin
         rsp_index_ff <= emit.index;
         rsp_value_ff <= emit.value;
         rsp_last_ff  <= emit.last;
      end
      if (accept && (req_func == lbfgs_pkg::FUNC_START)) begin
         n_ff <= n_eff;
         m_ff <= m_eff;
         h_ff <= req_h_scale;
         i_ff <= '0;
         j_ff <= '0;
      end
      if (in_pass) begin
         j_ff <= j_last ? '0 : j_ff + VAR_W'(1);
      end
      unique case (state_ff)
         S_RHO_DOT: after_ff <= S_RHO_DIV;
         S_BK_DOT:  after_ff <= S_BK_MUL;
         S_FW_DOT:  after_ff <= S_FW_MUL;
         S_BK_UPD:  after_ff <= (i_ff == '0) ? S_SCALE : S_BK_DOT;
         S_SCALE:   after_ff <= (m_ff == '0) ? S_OUT : S_FW_DOT;
         S_FW_UPD:  after_ff <= i_last ? S_OUT : S_FW_DOT;
         S_OUT:     after_ff <= S_IDLE;
         default: ;
      endcase
      // step index moves when a pass result has fully landed
      if (state_ff == S_DRAIN && !pipe_busy) begin
         if (after_ff == S_BK_DOT) i_ff <= i_ff - STEP_W'(1);
         if (after_ff == S_FW_DOT && state_in == S_FW_DOT && i_ff != '0) begin
            i_ff <= i_ff;
         end
      end
      if (state_ff == S_RHO_DIV) begin
         if (!div_run_ff && dot_sat == 32'sd0) begin
            rho_ff[i_ff] <= 32'sd0;
            i_ff <= i_last ? i_ff : i_ff + STEP_W'(1);
         end else if (div_run_ff && div_done) begin
            rho_ff[i_ff] <= div_q;
            i_ff <= i_last ? i_ff : i_ff + STEP_W'(1);
         end
      end
      if (state_ff == S_SCALE && j_last) begin
         i_ff <= '0;
      end
      if (state_ff == S_FW_UPD && j_last && !i_last) begin
         i_ff <= i_ff + STEP_W'(1);
      end
      if (state_ff == S_BK_MUL || state_ff == S_FW_MUL) begin
         cprod_ff <= rho_ff[i_ff] * dot_sat;
      end
      if (state_ff == S_BK_SAT) begin
         alpha_ff[i_ff] <= beta;
         coef_ff        <= beta;
      end
      if (state_ff == S_FW_SAT) begin
         coef_ff <= lbfgs_pkg::sat32(64'(alpha_ff[i_ff]) - 64'(beta));
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_index       = rsp_index_ff;
   assign rsp_direction_value = rsp_value_ff;
   assign rsp_last            = rsp_last_ff;
   assign rsp_curvature_error = err_ff;

   a_rsp_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result outside a run");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == lbfgs_pkg::FUNC_START) |=> busy)
      else $error("start did not begin a run");

   a_div_in_rho: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_RHO_DIV)) else $error("divider done outside rho phase");

   a_pass_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BK_MUL || state_ff == S_FW_MUL) |-> !pipe_busy)
      else $error("coefficient taken before pass drained");

endmodule

`default_nettype wire

/* test/lbfgs_two_loop_direction_top_test.sv */
// ----------------------------------------------------------------------------
// lbfgs_two_loop_direction_top_test
// Self-checking bench for the L-BFGS direction engine: loads history pairs
// and gradients, starts runs under several vector and pair counts, and
// compares every emitted direction element with an in-bench fixed point model.
// ----------------------------------------------------------------------------
`default_nettype none

module lbfgs_two_loop_direction_top_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int         VARS = 64;
   localparam int         STEPS = 8;
   localparam int         STALL_LIMIT = 20000;

   typedef struct {
      logic [5:0]  index;
      int          value;
      logic        last;
      logic        curv_err;
   } direction_elem_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_func = '0;
   logic [2:0]         req_step_index = '0;
   logic [5:0]         req_var_index = '0;
   logic signed [31:0] req_s_value = '0;
   logic signed [31:0] req_y_value = '0;
   logic signed [31:0] req_grad_value = '0;
   logic signed [31:0] req_h_scale = '0;
   logic               rsp_valid;
   logic [5:0]         rsp_out_index;
   logic signed [31:0] rsp_direction_value;
   logic               rsp_last;
   logic               rsp_curvature_error;
   logic               csr_we = 1'b0;
   logic               csr_index = 1'b0;
   logic [6:0]         csr_wdata = '0;

   // model state
   int   s_mem [STEPS*VARS];
   int   y_mem [STEPS*VARS];
   bit   pair_loaded [STEPS*VARS];
   int   work_vec [VARS];
   bit   work_loaded [VARS];
   int   rho_mem [STEPS];
   int   alpha_mem [STEPS];
   logic [6:0] vars_reg;
   logic [3:0] steps_reg;

   direction_elem_type direction_q[$];
   int   errors = 0;
   int   items_sent = 0;
   int   runs_done = 0;
   int   results_seen = 0;
   int   zero_curv_runs = 0;
   int   pause_pct = 0;
   int   stall_cycles = 0;

   lbfgs_two_loop_direction_top uut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic longint qmul(longint a, longint b);
      return (a * b) >>> 16;
   endfunction

   function automatic int sat(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return int'(v);
   endfunction

   function automatic int eff_vars();
      if (vars_reg == 0) return 1;
      if (vars_reg > VARS) return VARS;
      return vars_reg;
   endfunction

   function automatic int eff_steps();
      return (steps_reg > STEPS) ? STEPS : steps_reg;
   endfunction

   function automatic int rand_q();
      case ($urandom_range(9))
         0: return int'($urandom);
         1: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         default: return int'($urandom_range(0, 1 << 19)) - (1 << 18);
      endcase
   endfunction

   // s.y over pair i, or s/y against the work vector
   function automatic int dot_pair(int i, int which, int n);
      longint acc;
      acc = 0;
      for (int j = 0; j < n; j++) begin
         case (which)
            0: acc += qmul(s_mem[i*VARS+j], y_mem[i*VARS+j]);
            1: acc += qmul(s_mem[i*VARS+j], work_vec[j]);
            default: acc += qmul(y_mem[i*VARS+j], work_vec[j]);
         endcase
      end
      return sat(acc);
   endfunction

   task automatic compute_direction(input int h);
      int n, m, d, a, b, diff;
      bit curv;
      direction_elem_type e;
      n = eff_vars();
      m = eff_steps();
      curv = 0;
      for (int i = 0; i < m; i++) begin
         d = dot_pair(i, 0, n);
         if (d == 0) begin
            rho_mem[i] = 0;
            curv = 1;
         end else begin
            rho_mem[i] = sat(64'sd4294967296 / longint'(d));
         end
      end
      for (int i = m - 1; i >= 0; i--) begin
         a = sat(qmul(rho_mem[i], dot_pair(i, 1, n)));
         alpha_mem[i] = a;
         for (int j = 0; j < n; j++)
            work_vec[j] = sat(longint'(work_vec[j]) - qmul(a, y_mem[i*VARS+j]));
      end
      for (int j = 0; j < n; j++) work_vec[j] = sat(qmul(h, work_vec[j]));
      for (int i = 0; i < m; i++) begin
         b = sat(qmul(rho_mem[i], dot_pair(i, 2, n)));
         diff = sat(longint'(alpha_mem[i]) - longint'(b));
         for (int j = 0; j < n; j++)
            work_vec[j] = sat(longint'(work_vec[j]) + qmul(s_mem[i*VARS+j], diff));
      end
      if (curv) zero_curv_runs++;
      for (int j = 0; j < n; j++) begin
         e.index = 6'(j);
         e.value = work_vec[j];
         e.last = (j == n - 1);
         e.curv_err = curv;
         direction_q.push_back(e);
      end
   endtask

   task automatic report_mismatch(input string what, input longint exp_v, input longint got_v);
      $display("  error @%0t: %s expected %0d got %0d", $realtime, what, exp_v, got_v);
      errors++;
   endtask

   // drop start for a random run of cycles, each idle with the pause odds
   task automatic sender_pause();
      while ($urandom_range(99) < pause_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   // start is left high after the transfer; any caller that passes an edge
   // without sending must lower it first
   task automatic send_item(input logic [1:0] f, input logic [2:0] st, input logic [5:0] vi,
                            input int s, input int y, input int g, input int h);
      start          <= 1'b1;
      req_func       <= f;
      req_step_index <= st;
      req_var_index  <= vi;
      req_s_value    <= s;
      req_y_value    <= y;
      req_grad_value <= g;
      req_h_scale    <= h;
      do @(posedge clock); while (busy);
      items_sent++;
      case (f)
         lbfgs_pkg::FUNC_LOAD_PAIR: begin
            s_mem[st*VARS+vi] = s;
            y_mem[st*VARS+vi] = y;
            pair_loaded[st*VARS+vi] = 1;
         end
         lbfgs_pkg::FUNC_LOAD_GRAD: begin
            work_vec[vi] = g;
            work_loaded[vi] = 1;
         end
         lbfgs_pkg::FUNC_START: begin
            compute_direction(h);
            runs_done++;
         end
         default: ;
      endcase
      sender_pause();
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (direction_q.size() != 0 || busy) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [6:0] val);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == lbfgs_pkg::CSR_VARS) vars_reg = val;
      else steps_reg = val[3:0];
   endtask

   // load whatever the next run reads, zeroing some pairs' s to hit zero curvature
   task automatic load_operands(input bit reload_grad);
      int n, m;
      bit zero_s;
      n = eff_vars();
      m = eff_steps();
      for (int i = 0; i < m; i++) begin
         zero_s = ($urandom_range(9) == 0);
         for (int j = 0; j < n; j++)
            if (zero_s || !pair_loaded[i*VARS+j] || $urandom_range(3) == 0)
               send_item(lbfgs_pkg::FUNC_LOAD_PAIR, 3'(i), 6'(j), zero_s ? 0 : rand_q(),
                         rand_q(), 0, 0);
      end
      for (int j = 0; j < n; j++)
         if (reload_grad || !work_loaded[j])
            send_item(lbfgs_pkg::FUNC_LOAD_GRAD, 3'($urandom), 6'(j), rand_q(), rand_q(),
                      rand_q(), 0);
   endtask

   task automatic test_directed();
      // vars 0 acts as one element; extreme s, y, gradient and scale
      write_reg(lbfgs_pkg::CSR_VARS, 7'd0);
      write_reg(lbfgs_pkg::CSR_STEPS, 7'd1);
      send_item(lbfgs_pkg::FUNC_LOAD_PAIR, 3'd0, 6'd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0);
      send_item(lbfgs_pkg::FUNC_LOAD_GRAD, 3'd7, 6'd0, 0, 0, 32'sh7FFF_FFFF, 0);
      send_item(lbfgs_pkg::FUNC_START, 3'd0, 6'd0, 0, 0, 0, 32'sh8000_0000);
      // zero curvature on the only pair
      send_item(lbfgs_pkg::FUNC_LOAD_PAIR, 3'd0, 6'd0, 0, 32'sh0005_0000, 0, 0);
      send_item(lbfgs_pkg::FUNC_LOAD_GRAD, 3'd0, 6'd0, 0, 0, 32'sh0001_0000, 0);
      send_item(lbfgs_pkg::FUNC_START, 3'd0, 6'd0, 0, 0, 0, 32'sh0001_0000);
      // unused func, top indexes, and a start on the stale work vector
      send_item(FUNC_UNUSED, 3'd7, 6'd63, -1, -1, -1, -1);
      send_item(lbfgs_pkg::FUNC_LOAD_PAIR, 3'd7, 6'd63, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0);
      send_item(lbfgs_pkg::FUNC_LOAD_PAIR, 3'd0, 6'd0, 32'sh0002_0000, 32'sh0003_0000, 0, 0);
      send_item(lbfgs_pkg::FUNC_START, 3'd0, 6'd0, 0, 0, 0, 32'sh7FFF_FFFF);
      // two elements, no pairs: plain scaling, then pair count above the depth
      write_reg(lbfgs_pkg::CSR_VARS, 7'd2);
      write_reg(lbfgs_pkg::CSR_STEPS, 7'd0);
      send_item(lbfgs_pkg::FUNC_LOAD_GRAD, 3'd0, 6'd0, 0, 0, 32'sh8000_0000, 0);
      send_item(lbfgs_pkg::FUNC_LOAD_GRAD, 3'd0, 6'd1, 0, 0, 32'sh0000_8000, 0);
      send_item(lbfgs_pkg::FUNC_START, 3'd0, 6'd0, 0, 0, 0, 32'shFFFF_0000);
      write_reg(lbfgs_pkg::CSR_STEPS, 7'd15);
      write_reg(lbfgs_pkg::CSR_VARS, 7'd1);
      load_operands(1);
      send_item(lbfgs_pkg::FUNC_START, 3'd0, 6'd0, 0, 0, 0, 32'sh0000_4000);
   endtask

   task automatic test_random(input int pct, input int item_target);
      int v;
      int runs;
      pause_pct = pct;
      while (items_sent < item_target) begin
         case ($urandom_range(14))
            0: v = 64;
            1: v = $urandom_range(65, 127);
            2: v = 0;
            3: v = $urandom_range(9, 20);
            default: v = $urandom_range(1, 8);
         endcase
         write_reg(lbfgs_pkg::CSR_VARS, 7'(v));
         v = ($urandom_range(7) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
         // keep long vectors to few pairs so the item count stays modest
         if (eff_vars() > 20 && v > 1) v = $urandom_range(0, 1);
         else if (eff_vars() > 8 && v > 2) v = $urandom_range(0, 2);
         write_reg(lbfgs_pkg::CSR_STEPS, 7'(v));
         runs = (eff_vars() > 20) ? 1 : $urandom_range(1, 3);
         repeat (runs) begin
            load_operands($urandom_range(4) != 0);
            // noise: unused func and stray loads between runs
            repeat ($urandom_range(0, 2)) begin
               if ($urandom_range(1))
                  send_item(FUNC_UNUSED, 3'($urandom), 6'($urandom), int'($urandom),
                            int'($urandom), int'($urandom), int'($urandom));
               else
                  send_item(lbfgs_pkg::FUNC_LOAD_PAIR, 3'($urandom), 6'($urandom), rand_q(),
                            rand_q(), 0, 0);
            end
            send_item(lbfgs_pkg::FUNC_START, 3'($urandom), 6'($urandom), 0, 0, 0, rand_q());
         end
      end
   endtask

   // result check and stall watchdog
   always @(posedge clock) begin
      direction_elem_type e;
      if ((start && !busy) || rsp_valid) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout after %0d idle cycles", stall_cycles);
         $display("lbfgs_two_loop_direction_top: mismatch");
         $finish;
      end
      if (!reset && rsp_valid) begin
         results_seen++;
         if (direction_q.size() == 0) begin
            report_mismatch("unexpected result, index", -1, rsp_out_index);
         end else begin
            e = direction_q.pop_front();
            if (rsp_out_index !== e.index)
               report_mismatch("out_index", e.index, rsp_out_index);
            if (rsp_direction_value !== e.value)
               report_mismatch($sformatf("direction_value[%0d]", e.index), e.value,
                               rsp_direction_value);
            if (rsp_last !== e.last)
               report_mismatch($sformatf("last[%0d]", e.index), e.last, rsp_last);
            if (rsp_curvature_error !== e.curv_err)
               report_mismatch($sformatf("curvature_error[%0d]", e.index), e.curv_err,
                               rsp_curvature_error);
         end
      end
   end

   initial begin
      vars_reg = 7'd64;
      steps_reg = 4'd0;
      for (int i = 0; i < STEPS*VARS; i++) pair_loaded[i] = 0;
      for (int j = 0; j < VARS; j++) work_loaded[j] = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(6, items_sent + 70);
      test_random(88, items_sent + 65);
      test_random(0, items_sent + 65);

      wait_idle();
      repeat (20) @(posedge clock);
      if (direction_q.size() != 0)
         report_mismatch("results still expected", direction_q.size(), 0);
      $display("covered %0d items, %0d runs (%0d with zero curvature), %0d results",
               items_sent, runs_done, zero_curv_runs, results_seen);
      if (errors == 0) begin
         $display("lbfgs_two_loop_direction_top: match");
      end else begin
         $display("lbfgs_two_loop_direction_top: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* sim.f */
sv/lbfgs_pkg.sv
sv/lbfgs_divider.sv
sv/lbfgs_datapath.sv
sv/lbfgs_two_loop_direction_top.sv
test/lbfgs_two_loop_direction_top_test.sv
